// ===== rtl/core/mexp_pkg.sv =====
// Shared constants, types and control structs for the modular exponentiation block.
package mexp_pkg;

    // Datapath width; base, exponent and modulus are cut to this many bits
    localparam int OPERAND_WIDTH = 32;
    // Width of the stream payload and of the configuration registers
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int RCNT_W        = $clog2(PROD_W);
    localparam int CFG_IDX_W     = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPONENT = 1'b0,
        REG_MODULUS  = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST,
        S_MUL,
        S_RED,
        S_UPD,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic red;
        logic upd;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic exp_zero;
        logic red_last;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/mexp_datapath.sv =====
// Datapath: operand registers, two multipliers with bit-serial reducers, output register.
module mexp_datapath import mexp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [DATA_W-1:0] i_base,
    input  logic [DATA_W-1:0] i_exponent,
    input  logic [DATA_W-1:0] i_modulus,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_out_data,
    input  logic              i_out_ready
);

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0]      r_acc, r_sq, r_exp, r_mod;
    logic [PROD_W-1:0] r_prod_a, r_prod_s;
    logic [W-1:0]      r_rem_a, r_rem_s;
    logic [RCNT_W-1:0] r_cnt;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    logic [W-1:0]      w_mod_in, w_mod_eff;
    logic [PROD_W-1:0] w_prod_a, w_prod_s;

    // one restoring step: shift in a product bit, subtract modulus if it fits
    function automatic logic [W-1:0] red_step(input logic [W-1:0] rem,
                                              input logic         in_bit,
                                              input logic [W-1:0] m);
        logic [W:0] t;
        t = {rem, in_bit};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[W-1:0];
    endfunction

    assign w_mod_in  = i_modulus[W-1:0];
    assign w_mod_eff = (w_mod_in == '0) ? W'(1) : w_mod_in;
    assign w_prod_a  = r_acc * r_sq;
    assign w_prod_s  = r_sq * r_sq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= W'(1);
            r_sq  <= i_base[W-1:0];
            r_exp <= i_exponent[W-1:0];
            r_mod <= w_mod_eff;
        end else if (i_cmd.upd) begin
            if (r_exp[0]) begin
                r_acc <= r_rem_a;
            end
            r_sq  <= r_rem_s;
            r_exp <= r_exp >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod_a <= w_prod_a;
            r_prod_s <= w_prod_s;
            r_rem_a  <= '0;
            r_rem_s  <= '0;
            r_cnt    <= RCNT_W'(PROD_W - 1);
        end else if (i_cmd.red) begin
            r_rem_a  <= red_step(r_rem_a, r_prod_a[PROD_W-1], r_mod);
            r_rem_s  <= red_step(r_rem_s, r_prod_s[PROD_W-1], r_mod);
            r_prod_a <= r_prod_a << 1;
            r_prod_s <= r_prod_s << 1;
            r_cnt    <= r_cnt - RCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= DATA_W'(r_acc);
        end
    end

    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.red_last = (r_cnt == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// ===== rtl/core/mexp_ctrl.sv =====
// Controller: sequences load, multiply, reduce, update and result hand-off.
module mexp_ctrl import mexp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_TEST;
            S_TEST: n_state = i_status.exp_zero ? S_DONE : S_MUL;
            S_MUL:  n_state = S_RED;
            S_RED:  if (i_status.red_last) n_state = S_UPD;
            S_UPD:  n_state = S_TEST;
            S_DONE: if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_TEST: ;
            S_MUL:  o_cmd.mul  = 1'b1;
            S_RED:  o_cmd.red  = 1'b1;
            S_UPD:  o_cmd.upd  = 1'b1;
            S_DONE: o_cmd.emit = i_status.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/modular_exponentiation.sv =====
// The loop runs once per exponent bit, up to and including the highest set bit.
// Each exponent bit takes a test, a multiply, 64 restoring reduction steps and an update.
// Throughput: one request at a time; the next is taken once the result is in the output reg.
// Zero exponent: result 1, no reduction.
// Reset (i_rst_n low, synchronous): controller idle, output empty, exponent and modulus = 1.
module modular_exponentiation import mexp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // [31:0] base
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // [31:0] power_mod
    // configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    logic [DATA_W-1:0] r_exponent;
    logic [DATA_W-1:0] r_modulus;

    t_cmd    w_cmd;
    t_status w_status;

    // Config registers. Modulus saturates at its floor of 1 on a zero write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exponent <= DATA_W'(1);
            r_modulus  <= DATA_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_EXPONENT: r_exponent <= i_cfg_data;
                REG_MODULUS:  r_modulus  <= (i_cfg_data == '0) ? DATA_W'(1) : i_cfg_data;
                default: ;
            endcase
        end
    end

    // State machine: one request in flight, loop over exponent bits
    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Operands, the two mul/reduce lanes (acc*sq and sq*sq) and the result register
    mexp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_base      (s_axis_tdata),
        .i_exponent  (r_exponent),
        .i_modulus   (r_modulus),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_out_ready (m_axis_tready)
    );

endmodule

// ===== rtl/core/mexp_checker.sv =====
// Port-level checks for the modular exponentiation block, bound to the top level.
module mexp_checker import mexp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a result leaves only by being taken
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped without handshake");

    // one request at a time: busy right after taking a request
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // a result never appears the cycle after a request is taken
    a_out_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result appeared too early");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
